### src/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### src/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Types, constants and opcode names for the stack machine execute unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package smx_pkg;
  localparam int StackDepthDefault  = 64;
  localparam int GlobalCountDefault = 16;

  localparam logic [4:0] OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2,
    OP_AND = 5'd3, OP_OR = 5'd4, OP_XOR = 5'd5, OP_NOT = 5'd6, OP_LT = 5'd7,
    OP_EQ = 5'd8, OP_PRINT = 5'd9, OP_OUTCHAR = 5'd10, OP_PUSH = 5'd11,
    OP_BR = 5'd12, OP_BRF = 5'd13, OP_DROP = 5'd14, OP_GLOAD = 5'd15,
    OP_GSTORE = 5'd16, OP_HALT = 5'd17;

  localparam logic [2:0] ST_RUN = 3'd0, ST_HALT = 3'd1, ST_END = 3'd2,
    ST_BADOP = 3'd3, ST_STACK = 3'd4, ST_GLOBAL = 3'd5;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  typedef struct packed {
    logic [4:0]         opcode;
    logic signed [31:0] operand;
  } smx_in_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic               out_is_char;
    logic [2:0]         status;
  } smx_out_t;
endpackage

### src/smx_ram.sv
// ----------------------------------------------------------------------------
// smx_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/smx_front.sv
// ----------------------------------------------------------------------------
// smx_front
// Two-entry word queue between the input side and the execute engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module smx_front import smx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  smx_in_t in_word,
  output logic    avail,
  input  logic    take,
  output smx_in_t head
);
  smx_in_t    slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_take;

  assign full    = (count == 2'd2);
  assign avail   = (count != 2'd0);
  assign head    = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_take = take && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_take};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= in_word;
    end
  end

  `ASSERT_IMPL(a_q_bound, clk, rst, 1'b1, count <= 2'd2, "front queue count overflow")
endmodule

### src/smx_back.sv
// ----------------------------------------------------------------------------
// smx_back
// Execute engine: stack cache, global store, program counter, result buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module smx_back import smx_pkg::*; #(
  parameter int STACK_DEPTH  = StackDepthDefault,
  parameter int GLOBAL_COUNT = GlobalCountDefault
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     avail,
  output logic     take,
  input  smx_in_t  head,
  input  logic     cfg_we,
  input  logic     cfg_index,
  input  logic [15:0] cfg_data,
  output logic     empty,
  input  logic     pop,
  output smx_out_t result
);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int GAW = (GLOBAL_COUNT > 1) ? $clog2(GLOBAL_COUNT) : 1;

  // Two top-of-stack words are held in registers; deeper entries live in RAM.
  logic [15:0]   code_length, pc;
  logic [CW-1:0] count;
  logic [2:0]    stopped;
  logic [31:0]   top0, top1;
  logic [31:0]   globals [GLOBAL_COUNT];
  logic          out_full;
  smx_out_t      out_reg;
  logic          refill;

  logic [SAW-1:0] ram_waddr, ram_raddr;
  logic           ram_we;
  logic [31:0]    ram_wdata, ram_rdata;

  smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [4:0]  op;
  logic [31:0] arg;
  logic [1:0]  need;
  logic        grow, gok, fire;
  logic [2:0]  st;
  logic [15:0] nxt;
  logic [31:0] res;
  logic [CW-1:0] new_count;
  logic [GAW-1:0] gidx;
  logic [31:0] prod;

  assign op   = head.opcode;
  assign arg  = head.operand;
  assign gok  = !arg[31] && (arg < 32'(GLOBAL_COUNT));
  assign gidx = arg[GAW-1:0];
  assign prod = top1 * top0;
  // After any word that lowers the stack count, the engine stalls issue while the RAM refills the cache.
  // A result word leaving in this cycle frees the output register for the next one.
  assign fire = avail && (!out_full || pop) && !refill;
  assign take = fire;

  always_comb begin
    need = 2'd0;
    grow = 1'b0;
    case (op)
      OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_LT, OP_EQ: need = 2'd2;
      OP_NOT, OP_PRINT, OP_OUTCHAR, OP_BRF, OP_DROP, OP_GSTORE: need = 2'd1;
      OP_PUSH, OP_GLOAD: grow = 1'b1;
      default: need = 2'd0;
    endcase
  end

  always_comb begin
    st  = ST_RUN;
    nxt = pc;
    res = 32'd0;
    new_count = count;
    if (stopped != ST_RUN) begin
      st = stopped;
    end else if (pc >= code_length) begin
      st = ST_END;
    end else if (op > OP_HALT) begin
      st = ST_BADOP;
    end else if (op == OP_HALT) begin
      st = ST_HALT;
    end else if (count < CW'(need) || (grow && count == CW'(STACK_DEPTH))) begin
      st = ST_STACK;
    end else if ((op == OP_GLOAD || op == OP_GSTORE) && !gok) begin
      st = ST_GLOBAL;
    end else begin
      nxt = (op >= OP_PUSH && op <= OP_GSTORE && op != OP_DROP) ? pc + 16'd2 : pc + 16'd1;
      new_count = count - CW'(need) + CW'(grow) + ((need == 2'd2) ? CW'(1) :
                  ((op == OP_NOT) ? CW'(1) : CW'(0)));
      case (op)
        OP_ADD: res = top1 + top0;
        OP_SUB: res = top1 - top0;
        OP_MUL: res = prod;
        OP_AND: res = top1 & top0;
        OP_OR:  res = top1 | top0;
        OP_XOR: res = top1 ^ top0;
        OP_NOT: res = {31'd0, top0 == 32'd0};
        OP_LT:  res = {31'd0, $signed(top1) < $signed(top0)};
        OP_EQ:  res = {31'd0, top1 == top0};
        OP_PUSH: res = arg;
        OP_GLOAD: res = globals[gidx];
        OP_BR:  nxt = arg[15:0];
        OP_BRF: if (top0 == 32'd0) nxt = arg[15:0];
        default: res = 32'd0;
      endcase
    end
  end

  // Stack layout: top0 is entry count-1, top1 is entry count-2, RAM holds
  // entries below count-2 at their own index.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = SAW'(count - CW'(2));
    ram_wdata = top1;
    ram_raddr = SAW'(count - CW'(3));
    if (fire && st == ST_RUN && grow && count >= CW'(2)) begin
      ram_we = 1'b1;
    end
    if (refill) begin
      ram_raddr = SAW'(count - CW'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_length   <= 16'd0;
      pc            <= 16'd0;
      count         <= '0;
      stopped       <= ST_RUN;
      out_full      <= 1'b0;
      refill        <= 1'b0;
      for (int i = 0; i < GLOBAL_COUNT; i++) globals[i] <= 32'd0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_START) begin
        pc            <= cfg_data;
        count         <= '0;
        stopped       <= ST_RUN;
      end else begin
        code_length <= cfg_data;
      end
    end else begin
      if (pop && out_full && !fire) begin
        out_full <= 1'b0;
      end
      refill <= 1'b0;
      if (refill && count >= CW'(2)) begin
        top1 <= ram_rdata;
      end
      if (fire) begin
        out_full            <= 1'b1;
        out_reg.next_pc     <= nxt;
        out_reg.status      <= st;
        out_reg.out_valid   <= 1'b0;
        out_reg.out_value   <= 32'd0;
        out_reg.out_is_char <= 1'b0;
        if (st != ST_RUN) begin
          stopped <= st;
        end else begin
          pc    <= nxt;
          count <= new_count;
          if (op == OP_PRINT || op == OP_OUTCHAR) begin
            out_reg.out_valid   <= 1'b1;
            out_reg.out_value   <= top0;
            out_reg.out_is_char <= (op == OP_OUTCHAR);
          end
          if (op == OP_GSTORE) begin
            globals[gidx] <= top0;
          end
          if (grow) begin
            top0 <= res;
            top1 <= top0;
          end else if (need == 2'd2 || op == OP_NOT) begin
            top0 <= res;
            if (need == 2'd2) refill <= 1'b1;
          end else if (need == 2'd1) begin
            top0 <= top1;
            refill <= 1'b1;
          end
        end
      end
    end
  end

  assign empty  = !out_full;
  assign result = out_reg;

  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(STACK_DEPTH), "stack count over depth")
  `ASSERT_NEXT(a_no_fire_refill, clk, rst, fire && !cfg_we, !fire || !refill, "issue during refill")
  `ASSERT_IMPL(a_stop_hold, clk, rst, stopped != ST_RUN && fire, st == stopped, "stop not held")
endmodule

### src/stack_machine_execute_unit.sv
// A pushed word is held in the input queue, then issued; its result is registered.
// Throughput: one word per cycle while the result slot is free or popped; a word that
// lowers the stack stalls issue while the cached second entry refills from the stack RAM.
// Reset: synchronous; pc, stack count, status and globals clear, stack RAM is
// not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Top level: input queue feeding the stack machine execute engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stack_machine_execute_unit import smx_pkg::*; #(
  parameter int STACK_DEPTH  = StackDepthDefault,
  parameter int GLOBAL_COUNT = GlobalCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  smx_in_t     in_word,
  output logic        empty,
  input  logic        pop,
  output smx_out_t    out_word,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  logic    avail, take;
  smx_in_t head;

  smx_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_word(in_word),
    .avail(avail), .take(take), .head(head)
  );

  smx_back #(.STACK_DEPTH(STACK_DEPTH), .GLOBAL_COUNT(GLOBAL_COUNT)) u_back (
    .clk(clk), .rst(rst), .avail(avail), .take(take), .head(head),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .empty(empty), .pop(pop), .result(out_word)
  );
endmodule
